// ===== hdl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared widths, register indexes and control structures of the Collatz
// step counter.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int VALUE_W   = 128;
	localparam int START_W   = 64;
	localparam int CFG_W     = 24;
	localparam int CNT_W     = 25;
	localparam int DIGIT_W   = 32;
	localparam int NUM_DIG   = VALUE_W / DIGIT_W;
	localparam int DIG_CNT_W = $clog2(NUM_DIG + 1);
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 1'b1;

	localparam logic [CFG_W-1:0] THRESHOLD_RST = 24'd1000;
	localparam logic [CFG_W-1:0] LIMIT_RST     = 24'd10000;

	typedef struct packed {
		logic load;
		logic shift;
		logic odd_mode;
		logic first;
		logic second;
		logic last;
	} sr_ctl_t;

	typedef struct packed {
		logic odd;
		logic above;
		logic carry_out;
	} sr_stat_t;

endpackage

// ===== hdl/cst_if.sv =====
// ----------------------------------------------------------------------------
// cst_if
// Handshake channels of the Collatz step counter: start values, results
// and configuration writes.
// ----------------------------------------------------------------------------
interface cst_start_if import cst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [START_W-1:0] start_value;

	modport source (output valid, output start_value, input ready);
	modport sink   (input valid, input start_value, output ready);
endinterface

interface cst_result_if import cst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [START_W-1:0] echo_start;
	logic [CNT_W-1:0]   step_count;
	logic               overflowed;

	modport source (output valid, output echo_start, output step_count,
		output overflowed, input ready);
	modport sink   (input valid, input echo_start, input step_count,
		input overflowed, output ready);
endinterface

interface cst_cfg_if import cst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cst_digit_alu.sv =====
// ----------------------------------------------------------------------------
// cst_digit_alu
// One digit of the serial update: the digit plus carry, or three times the
// digit plus carry when the working value is odd.
// ----------------------------------------------------------------------------
module cst_digit_alu import cst_pkg::*; (
	input  logic [DIGIT_W-1:0] digit,
	input  logic [1:0]         carry_in,
	input  logic               odd_mode,
	output logic [DIGIT_W+1:0] sum
);

	logic [DIGIT_W+1:0] twice;

	assign twice = odd_mode ? {1'b0, digit, 1'b0} : '0;
	assign sum   = {2'b00, digit} + twice + {{DIGIT_W{1'b0}}, carry_in};

endmodule

// ===== hdl/cst_value_sr.sv =====
// ----------------------------------------------------------------------------
// cst_value_sr
// Working value held in a rotating shift register. Each pass moves the word
// through the digit unit one digit per cycle, halving the result with a
// one-digit lag, and gathers parity, magnitude and overflow for the next step.
// ----------------------------------------------------------------------------
module cst_value_sr import cst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  sr_ctl_t            ctl,
	input  logic [START_W-1:0] start_value,
	output sr_stat_t           stat
);

	logic [VALUE_W-1:0] w_q;
	logic [DIGIT_W-1:0] tdig_q;
	logic [1:0]         carry_q;
	logic               odd_q;
	logic               above_q;
	logic               nz_q;
	logic [1:0]         carry_in;
	logic [DIGIT_W+1:0] sum;
	logic [DIGIT_W-1:0] ins;

	assign carry_in = ctl.first ? {1'b0, ctl.odd_mode} : carry_q;

	cst_digit_alu u_alu (
		.digit    (w_q[DIGIT_W-1:0]),
		.carry_in (carry_in),
		.odd_mode (ctl.odd_mode),
		.sum      (sum)
	);

	assign ins = {(ctl.last ? 1'b0 : sum[0]), tdig_q[DIGIT_W-1:1]};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			w_q <= {{(VALUE_W-START_W){1'b0}}, start_value};
		end else if (ctl.shift) begin
			w_q     <= {ins, w_q[VALUE_W-1:DIGIT_W]};
			tdig_q  <= sum[DIGIT_W-1:0];
			carry_q <= sum[DIGIT_W+1:DIGIT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q   <= 1'b0;
			above_q <= 1'b0;
			nz_q    <= 1'b0;
		end else if (ctl.load) begin
			odd_q   <= start_value[0];
			above_q <= |start_value[START_W-1:1];
		end else if (ctl.shift) begin
			if (ctl.first) begin
				nz_q <= 1'b0;
			end else if (ctl.second) begin
				nz_q  <= |ins[DIGIT_W-1:1];
				odd_q <= ins[0];
			end else begin
				nz_q <= nz_q | (|ins);
			end
			if (ctl.last) begin
				above_q <= nz_q | (|ins);
			end
		end
	end

	assign stat.odd       = odd_q;
	assign stat.above     = above_q;
	assign stat.carry_out = |carry_q;

endmodule

// ===== hdl/cst_ctrl.sv =====
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer of the step counter: checks the stop condition before each
// iteration, runs one serial pass per iteration and counts the steps.
// ----------------------------------------------------------------------------
module cst_ctrl import cst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start_fire,
	input  logic [CFG_W-1:0] threshold,
	input  logic [CFG_W-1:0] limit,
	input  logic             out_free,
	input  sr_stat_t         stat,
	output sr_ctl_t          ctl,
	output logic             idle,
	output logic             res_fire,
	output logic [CNT_W-1:0] res_count,
	output logic             res_ovf
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_PASS  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic [DIG_CNT_W-1:0] dig_q;
	logic                 mode_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 ovf_q;
	logic                 go;
	logic                 emit;

	assign go   = stat.above && ({1'b0, limit} > cnt_q);
	assign emit = ovf_q || (cnt_q >= {1'b0, threshold});

	assign ctl.load     = start_fire;
	assign ctl.shift    = (state_q == ST_PASS);
	assign ctl.odd_mode = mode_q;
	assign ctl.first    = (dig_q == '0);
	assign ctl.second   = (dig_q == DIG_CNT_W'(1));
	assign ctl.last     = (dig_q == DIG_CNT_W'(NUM_DIG));

	assign idle      = (state_q == ST_IDLE);
	assign res_fire  = (state_q == ST_DONE) && emit && out_free;
	assign res_count = cnt_q;
	assign res_ovf   = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dig_q   <= '0;
			mode_q  <= 1'b0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_fire) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (go) begin
						mode_q  <= stat.odd;
						dig_q   <= '0;
						state_q <= ST_PASS;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_PASS: begin
					if (ctl.last) begin
						if (stat.carry_out) begin
							ovf_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							cnt_q   <= cnt_q + (mode_q ? CNT_W'(2) : CNT_W'(1));
							state_q <= ST_CHECK;
						end
					end else begin
						dig_q <= dig_q + DIG_CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (!emit || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/collatz_step_counter_top.sv =====
// ----------------------------------------------------------------------------
// collatz_step_counter_top
// Counts Collatz steps of each start value on a 128-bit working value that is
// processed 32 bits per cycle, and reports start value and count when the
// count reaches the threshold or the working value would overflow.
// Each iteration is one check and a serial pass over the four digits; a closing
// check and the move to the output register end each run.
// Throughput: one start value at a time; the next request is taken once the
// result has moved to the output register, which may still wait there.
// Reset clears the control state and sets threshold 1000 and limit 10000.
// ----------------------------------------------------------------------------
module collatz_step_counter_top import cst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	cst_start_if.sink    start,
	cst_result_if.source result,
	cst_cfg_if.sink      cfg
);

	logic [CFG_W-1:0]   threshold_q;
	logic [CFG_W-1:0]   limit_q;
	logic [START_W-1:0] held_start_q;
	logic               out_valid_q;
	logic [START_W-1:0] echo_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic               idle;
	logic               start_fire;
	logic               out_free;
	logic               res_fire;
	logic [CNT_W-1:0]   res_count;
	logic               res_ovf;
	sr_ctl_t            ctl;
	sr_stat_t           stat;

	assign start.ready = idle;
	assign start_fire  = start.valid && idle;
	assign cfg.ready   = 1'b1;
	assign out_free    = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			limit_q     <= LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_THRESHOLD: threshold_q <= cfg.data;
				REG_LIMIT:     limit_q     <= cfg.data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_fire) begin
			held_start_q <= start.start_value;
		end
		if (res_fire) begin
			echo_q  <= held_start_q;
			count_q <= res_count;
			ovf_q   <= res_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	cst_value_sr u_value (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.start_value (start.start_value),
		.stat        (stat)
	);

	cst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_fire (start_fire),
		.threshold  (threshold_q),
		.limit      (limit_q),
		.out_free   (out_free),
		.stat       (stat),
		.ctl        (ctl),
		.idle       (idle),
		.res_fire   (res_fire),
		.res_count  (res_count),
		.res_ovf    (res_ovf)
	);

	assign result.valid      = out_valid_q;
	assign result.echo_start = echo_q;
	assign result.step_count = count_q;
	assign result.overflowed = ovf_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Collatz step counter. Start values are offered
// from a queue and the expected reports are computed by an independent
// trajectory tracer. Every report is checked field by field against the
// oldest expectation, over several threshold and limit settings and several
// mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import cst_pkg::*;

	localparam int HOLDOFF_CYCLES = 3000;
	localparam int QUIET_LIMIT    = 100000;
	localparam int SEGMENT_ITEMS  = 100;

	typedef struct {
		logic [START_W-1:0] echo_start;
		logic [CNT_W-1:0]   step_count;
		logic               overflowed;
	} collatz_report_t;

	logic clk;
	logic arst_n;

	cst_start_if  start_ch ();
	cst_result_if result_ch ();
	cst_cfg_if    cfg_ch ();

	collatz_step_counter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic [START_W-1:0] pending_starts[$];
	collatz_report_t    expected_reports[$];

	logic [CFG_W-1:0] threshold_cfg = THRESHOLD_RST;
	logic [CFG_W-1:0] limit_cfg     = LIMIT_RST;

	logic            start_fire = 1'b0;
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              holdoff_req = 0;
	int              holdoff_seen = 0;
	int              holdoff_left = 0;
	int              last_iters = 0;
	int              quiet_cycles = 0;
	int              mismatch_count = 0;
	collatz_report_t predicted;
	logic            predicted_emit;
	int              predicted_iters;
	collatz_report_t wanted;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Walks the trajectory on a working value two bits wider than the block's,
	// so that a tripled value that no longer fits can be seen.
	function automatic void trace_collatz(input logic [START_W-1:0] start_val,
		input logic [CFG_W-1:0] threshold, input logic [CFG_W-1:0] limit,
		output collatz_report_t rep, output logic emit, output int iters);
		logic [VALUE_W+1:0] work;
		logic [VALUE_W+1:0] tripled;
		logic [CNT_W-1:0]   steps;
		logic               ovf;
		work  = (VALUE_W+2)'(start_val);
		steps = '0;
		ovf   = 1'b0;
		iters = 0;
		while (work > 1 && steps < limit) begin
			iters++;
			if (work[0]) begin
				tripled = work * 3 + 1;
				if (tripled[VALUE_W+1:VALUE_W] != 2'b00) begin
					ovf = 1'b1;
					break;
				end
				work  = tripled;
				steps = steps + 1'b1;
			end
			work  = work >> 1;
			steps = steps + 1'b1;
		end
		rep.echo_start = start_val;
		rep.step_count = steps;
		rep.overflowed = ovf;
		emit = ovf || (steps >= threshold);
	endfunction

	function automatic logic [START_W-1:0] random_start();
		logic [START_W-1:0] raw;
		int                 pick;
		raw  = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 15)
			return raw;
		if (pick < 30)
			return START_W'($urandom_range(1000));
		return raw >> $urandom_range(63, 1);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_THRESHOLD)
			threshold_cfg = value;
		else
			limit_cfg = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] threshold,
		input logic [CFG_W-1:0] limit);
		write_register(REG_THRESHOLD, threshold);
		write_register(REG_LIMIT, limit);
	endtask

	task automatic drain();
		while (pending_starts.size() != 0 || expected_reports.size() != 0)
			@(posedge clk);
		repeat (8 * last_iters + 40) @(posedge clk);
	endtask

	task automatic queue_random(input int count);
		repeat (count) pending_starts.push_back(random_start());
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (start_fire)
				void'(pending_starts.pop_front());
			if (!start_ch.valid || start_fire) begin
				if (pending_starts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					start_ch.valid       <= 1'b1;
					start_ch.start_value <= pending_starts[0];
				end else begin
					start_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (holdoff_left != 0) begin
			holdoff_left    <= holdoff_left - 1;
			result_ch.ready <= 1'b0;
		end else if (holdoff_req != holdoff_seen) begin
			holdoff_seen    <= holdoff_req;
			holdoff_left    <= HOLDOFF_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			start_fire <= start_ch.valid && start_ch.ready;
			if (start_ch.valid && start_ch.ready) begin
				trace_collatz(start_ch.start_value, threshold_cfg, limit_cfg,
					predicted, predicted_emit, predicted_iters);
				if (predicted_emit)
					expected_reports.push_back(predicted);
				last_iters = predicted_iters;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("report for start %0h with none outstanding",
						result_ch.echo_start));
				end else begin
					wanted = expected_reports.pop_front();
					if (result_ch.echo_start !== wanted.echo_start)
						report_mismatch($sformatf("echo_start %0h, expected %0h",
							result_ch.echo_start, wanted.echo_start));
					if (result_ch.step_count !== wanted.step_count)
						report_mismatch($sformatf("step_count %0d for start %0h, expected %0d",
							result_ch.step_count, wanted.echo_start, wanted.step_count));
					if (result_ch.overflowed !== wanted.overflowed)
						report_mismatch($sformatf("overflowed %0b for start %0h, expected %0b",
							result_ch.overflowed, wanted.echo_start, wanted.overflowed));
				end
			end
			if ((start_ch.valid && start_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		start_ch.valid       = 1'b0;
		start_ch.start_value = '0;
		result_ch.ready      = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = REG_THRESHOLD;
		cfg_ch.data          = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Settings left at their reset values: only long trajectories report.
		pending_starts = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd27, 64'd9780657630,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};
		drain();

		// A zero limit stops every request before its first step.
		configure(24'd0, 24'd0);
		pending_starts = '{64'd0, 64'd1, 64'd7, 64'hFFFF_FFFF_FFFF_FFFF};
		drain();

		// An odd value under a limit of one runs past the limit by one step.
		configure(24'd0, 24'd1);
		pending_starts = '{64'd3, 64'd4, 64'd1};
		drain();

		configure(24'hFF_FFFF, 24'hFF_FFFF);
		pending_starts = '{64'd27, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9780657630};
		drain();

		configure(24'd0, 24'hFF_FFFF);
		pending_starts = '{64'd27, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'd2, 64'hAAAA_AAAA_AAAA_AAAB};
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 87 : (phase == 3) ? 33 : 0;
			recv_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 33 : 0;
			for (int seg = 0; seg < 3; seg++) begin
				case (phase)
					0: configure(CFG_W'($urandom_range(150)), LIMIT_RST);
					1: configure(CFG_W'($urandom_range(150)), CFG_W'($urandom_range(400, 20)));
					2: configure(CFG_W'($urandom_range(150)), 24'hFF_FFFF);
					default: configure(CFG_W'($urandom_range(300)),
						CFG_W'($urandom_range(2000, 100)));
				endcase
				queue_random(SEGMENT_ITEMS);
				drain();
			end
		end

		// The receiver holds off while requests keep coming, so the block fills up.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		configure(24'd0, LIMIT_RST);
		holdoff_req++;
		repeat (30) pending_starts.push_back(START_W'($urandom_range(5000)));
		drain();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
